// ===== src/mps_pkg.sv =====
// shared types, constants and helper functions for the motion path sampler
package mps_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_HORIZON   = 3'd0;
  localparam logic [2:0] CFG_STEP      = 3'd1;
  localparam logic [2:0] CFG_SIGMA0    = 3'd2;
  localparam logic [2:0] CFG_START_ACC = 3'd3;
  localparam logic [2:0] CFG_SPEED_RT  = 3'd4;

  // configuration reset values
  localparam logic [23:0] HORIZON_RST   = 24'd327680;
  localparam logic [23:0] STEP_RST      = 24'd32768;
  localparam logic [30:0] SIGMA0_RST    = 31'd32768;
  localparam logic [30:0] START_ACC_RST = 31'd65536;
  localparam logic [30:0] SPEED_RT_RST  = 31'd32768;

  // divider widths
  localparam int DIV_W = 25;
  localparam int DVS_W = 24;

  // heading limits and pre-rotation angle (pi in Q.24)
  localparam logic signed [31:0] HEAD_MAX = 32'sd205887;
  localparam logic signed [31:0] PI_Q24   = 32'sd52707179;

  // top level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_CNT, ST_HDIV, ST_SQ, ST_VEC, ST_PT, ST_OUT
  } state_t;

  // vector unit states
  typedef enum logic [1:0] {
    VS_IDLE, VS_ROOT, VS_ANGLE, VS_DONE
  } vec_state_t;

  // divider status
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // vector unit status
  typedef struct packed {
    logic               done;
    logic [30:0]        speed;
    logic signed [18:0] heading;
  } vec_rsp_t;

  // arctangent table in Q.24
  function automatic logic [23:0] atan_q24(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // saturate a non-negative value to 31 bits
  function automatic logic [30:0] satu31(input logic [47:0] v);
    logic [30:0] r;
    if (v > 48'h7FFFFFFF) begin
      r = 31'h7FFFFFFF;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ===== src/mps_mult.sv =====
// shared signed multiplier with registered product
module mps_mult (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p
);

  logic signed [67:0] p_r;

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== src/mps_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module mps_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mps_pkg::DIV_W-1:0] dividend,
  input  logic [mps_pkg::DVS_W-1:0] divisor,
  output mps_pkg::div_rsp_t         rsp
);

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                cnt_r;
  logic [mps_pkg::DVS_W:0]   rem_r;
  logic [mps_pkg::DIV_W-1:0] quo_r;
  logic [mps_pkg::DVS_W-1:0] dvs_r;
  logic [mps_pkg::DVS_W:0]   shifted;
  logic [mps_pkg::DVS_W:0]   diff;
  logic                      fits;

  // partial remainder trial
  assign shifted = {rem_r[mps_pkg::DVS_W-1:0], quo_r[mps_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(mps_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff : shifted;
      quo_r <= {quo_r[mps_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp = {done_r, quo_r, rem_r[mps_pkg::DVS_W-1:0]};

endmodule

// ===== src/mps_vector.sv =====
// velocity norm by bit-serial square root, then heading by iterative cordic
module mps_vector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        sum_sq,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  output mps_pkg::vec_rsp_t  rsp
);

  mps_pkg::vec_state_t state_r;
  mps_pkg::vec_state_t state_nxt;
  logic [4:0]          iter_r;
  logic [63:0]         rem_r;
  logic [63:0]         root_r;
  logic [63:0]         bit_r;
  logic signed [63:0]  x_r;
  logic signed [63:0]  y_r;
  logic signed [31:0]  z_r;
  logic [63:0]         trial;
  logic signed [63:0]  xs;
  logic signed [63:0]  ys;
  logic signed [63:0]  vx_sc;
  logic signed [63:0]  vy_sc;
  logic signed [31:0]  ang;
  logic signed [31:0]  z_rnd;
  logic                done_c;
  logic signed [18:0]  hd_c;
  logic [30:0]         spd_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mps_pkg::VS_IDLE:  if (start) state_nxt = mps_pkg::VS_ROOT;
      mps_pkg::VS_ROOT:  if (iter_r == 5'd31) state_nxt = mps_pkg::VS_ANGLE;
      mps_pkg::VS_ANGLE: if (iter_r == 5'd23) state_nxt = mps_pkg::VS_DONE;
      mps_pkg::VS_DONE:  state_nxt = mps_pkg::VS_IDLE;
      default:           state_nxt = mps_pkg::VS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_c = 1'b0;
    case (state_r)
      mps_pkg::VS_DONE: done_c = 1'b1;
      default:          done_c = 1'b0;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mps_pkg::VS_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= (state_nxt != state_r) ? 5'd0 : iter_r + 5'd1;
    end
  end

  // shared terms
  assign trial = root_r + bit_r;
  assign xs    = x_r >>> iter_r;
  assign ys    = y_r >>> iter_r;
  assign vx_sc = {{3{vx[31]}}, vx, 29'b0};
  assign vy_sc = {{3{vy[31]}}, vy, 29'b0};
  assign ang   = $signed({8'b0, mps_pkg::atan_q24(iter_r)});

  // root and cordic datapath
  always_ff @(posedge clk) begin
    if (state_r == mps_pkg::VS_IDLE && start) begin
      rem_r  <= sum_sq;
      root_r <= '0;
      bit_r  <= 64'h4000000000000000;
      if (vx < 0) begin
        x_r <= -vx_sc;
        y_r <= -vy_sc;
        z_r <= (vy >= 0) ? mps_pkg::PI_Q24 : -mps_pkg::PI_Q24;
      end else begin
        x_r <= vx_sc;
        y_r <= vy_sc;
        z_r <= '0;
      end
    end else if (state_r == mps_pkg::VS_ROOT) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end else if (state_r == mps_pkg::VS_ANGLE) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
    end
  end

  // round the angle to Q3.16 and clamp
  assign z_rnd = (z_r + 32'sd128) >>> 8;
  always_comb begin
    if (z_rnd > mps_pkg::HEAD_MAX) begin
      hd_c = mps_pkg::HEAD_MAX[18:0];
    end else if (z_rnd < -mps_pkg::HEAD_MAX) begin
      hd_c = 19'(-mps_pkg::HEAD_MAX);
    end else begin
      hd_c = z_rnd[18:0];
    end
  end

  assign spd_c = (root_r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : root_r[30:0];
  assign rsp   = {done_c, spd_c, hd_c};

endmodule

// ===== src/motion_path_sampler_unit.sv =====
// motion path sampler top level: sequencer, configuration and output register
//
// Takes one target snapshot per request and emits count+1 predicted points,
// count = ceil(horizon/step) held to 1..MAX_INTERVALS, at times
// floor(horizon*i/count). One request occupies the block for its accept
// cycle, setup (two divisions on the shared divider), then, for the
// constant-velocity model with nonzero velocity, the squaring products,
// 32 square root steps, 24 cordic steps and the finish state on the
// vector unit, then six products per point on the single shared
// multiplier, plus any output stalls. in_tready is high only while the
// block is idle. The point times advance by adding the quotient and
// remainder of horizon/count.
module motion_path_sampler_unit #(
  parameter int MAX_INTERVALS = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  // input requests
  input  logic         in_tvalid,
  output logic         in_tready,
  // tgt id, pos_x, pos_y, vel_x, vel_y, yaw, lateral_accel
  input  logic [215:0] in_tdata,
  // action
  input  logic [0:0]   in_tuser,
  // predicted points
  output logic         out_tvalid,
  input  logic         out_tready,
  // out tgt id, sample_time, pred_x, pred_y, heading, speed,
  // sigma_along, sigma_cross
  output logic [239:0] out_tdata,
  // model_kind
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  // configuration writes
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  mps_pkg::state_t    state_r;
  mps_pkg::state_t    state_nxt;

  logic [23:0]        horizon_r;
  logic [23:0]        step_r;
  logic [30:0]        sig0_r;
  logic [30:0]        acc_r;
  logic [30:0]        rate_r;

  logic               mode_r;
  logic [31:0]        id_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic signed [31:0] lat_r;
  logic signed [18:0] hd_r;
  logic [30:0]        spd_r;

  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      idx_r;
  logic [2:0]         op_r;
  logic [23:0]        t_r;
  logic [CW-1:0]      trem_r;
  logic [23:0]        hq_r;
  logic [CW-1:0]      hr_r;
  logic [32:0]        t2_r;
  logic [63:0]        sq_r;
  logic signed [31:0] qx_r;
  logic signed [31:0] qy_r;
  logic [30:0]        sa_r;
  logic signed [31:0] sc_r;

  logic [239:0]       out_tdata_r;
  logic               out_tuser_r;
  logic               out_tlast_r;

  logic                      div_start;
  logic [mps_pkg::DIV_W-1:0] div_dividend;
  logic [mps_pkg::DVS_W-1:0] div_divisor;
  mps_pkg::div_rsp_t         div_rsp;
  logic                      vec_start;
  mps_pkg::vec_rsp_t         vec_rsp;
  logic signed [33:0]        mul_a;
  logic signed [33:0]        mul_b;
  logic signed [67:0]        mul_p;
  logic signed [67:0]        rnd16;
  logic signed [67:0]        rnd17;
  logic [CW-1:0]             cnt_nxt;
  logic [31:0]               ax;
  logic [31:0]               ay;
  logic [30:0]               ss;
  logic [CW:0]               rem_sum;
  logic                      last_pt;
  logic                      moving;

  // shared units
  mps_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  mps_vector u_vec (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (vec_start),
    .sum_sq (sq_r + mul_p[63:0]),
    .vx     (vx_r),
    .vy     (vy_r),
    .rsp    (vec_rsp)
  );

  mps_mult u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // interval count from the first division
  always_comb begin
    if (step_r == '0 || div_rsp.quot > mps_pkg::DIV_W'(MAX_INTERVALS)) begin
      cnt_nxt = CW'(MAX_INTERVALS);
    end else if (div_rsp.quot == '0) begin
      cnt_nxt = CW'(1);
    end else begin
      cnt_nxt = div_rsp.quot[CW-1:0];
    end
  end

  assign last_pt = (idx_r == cnt_r);
  assign moving  = mode_r && (vx_r != '0 || vy_r != '0);
  assign ax      = vx_r[31] ? 32'(-vx_r) : vx_r;
  assign ay      = vy_r[31] ? 32'(-vy_r) : vy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mps_pkg::ST_IDLE: if (in_tvalid) state_nxt = mps_pkg::ST_CNT;
      mps_pkg::ST_CNT:  if (div_rsp.done) state_nxt = mps_pkg::ST_HDIV;
      mps_pkg::ST_HDIV: begin
        if (div_rsp.done) state_nxt = moving ? mps_pkg::ST_SQ : mps_pkg::ST_PT;
      end
      mps_pkg::ST_SQ:   if (op_r == 3'd2) state_nxt = mps_pkg::ST_VEC;
      mps_pkg::ST_VEC:  if (vec_rsp.done) state_nxt = mps_pkg::ST_PT;
      mps_pkg::ST_PT:   if (op_r == 3'd6) state_nxt = mps_pkg::ST_OUT;
      mps_pkg::ST_OUT: begin
        if (out_tready) state_nxt = last_pt ? mps_pkg::ST_IDLE : mps_pkg::ST_PT;
      end
      default:          state_nxt = mps_pkg::ST_IDLE;
    endcase
  end

  // handshake and unit starts
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    div_start    = 1'b0;
    vec_start    = 1'b0;
    div_dividend = {1'b0, horizon_r} + {1'b0, step_r} - 25'd1;
    div_divisor  = step_r;
    case (state_r)
      mps_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid;
      end
      mps_pkg::ST_CNT: begin
        div_start    = div_rsp.done;
        div_dividend = {1'b0, horizon_r};
        div_divisor  = mps_pkg::DVS_W'(cnt_nxt);
      end
      mps_pkg::ST_SQ:  vec_start  = (op_r == 3'd2);
      mps_pkg::ST_OUT: out_tvalid = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == mps_pkg::ST_SQ) begin
      mul_a = (op_r == 3'd0) ? {2'b0, ax} : {2'b0, ay};
      mul_b = mul_a;
    end else if (state_r == mps_pkg::ST_PT) begin
      case (op_r)
        3'd0: begin mul_a = {10'b0, t_r}; mul_b = {10'b0, t_r}; end
        3'd1: begin mul_a = {{2{vx_r[31]}}, vx_r}; mul_b = {10'b0, t_r}; end
        3'd2: begin mul_a = {{2{vy_r[31]}}, vy_r}; mul_b = {10'b0, t_r}; end
        3'd3: begin mul_a = {3'b0, rate_r}; mul_b = {10'b0, t_r}; end
        3'd4: begin mul_a = {{2{lat_r[31]}}, lat_r}; mul_b = {1'b0, t2_r}; end
        3'd5: begin mul_a = {3'b0, acc_r}; mul_b = {1'b0, t2_r}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // rounded products
  assign rnd16   = (mul_p + 68'sd32768) >>> 16;
  assign rnd17   = (mul_p + 68'sd65536) >>> 17;
  assign ss      = mps_pkg::satu31({17'b0, sig0_r} + rnd17[47:0]);
  assign rem_sum = {1'b0, trem_r} + {1'b0, hr_r};

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mps_pkg::ST_IDLE;
      op_r      <= '0;
      horizon_r <= mps_pkg::HORIZON_RST;
      step_r    <= mps_pkg::STEP_RST;
      sig0_r    <= mps_pkg::SIGMA0_RST;
      acc_r     <= mps_pkg::START_ACC_RST;
      rate_r    <= mps_pkg::SPEED_RT_RST;
    end else begin
      state_r <= state_nxt;
      op_r    <= (state_nxt != state_r) ? 3'd0 : op_r + 3'd1;
      if (cfg_wr_en) begin
        case (cfg_index)
          mps_pkg::CFG_HORIZON:   horizon_r <= cfg_data[23:0];
          mps_pkg::CFG_STEP:      step_r    <= cfg_data[23:0];
          mps_pkg::CFG_SIGMA0:    sig0_r    <= cfg_data;
          mps_pkg::CFG_START_ACC: acc_r     <= cfg_data;
          mps_pkg::CFG_SPEED_RT:  rate_r    <= cfg_data;
          default:                horizon_r <= horizon_r;
        endcase
      end
    end
  end

  // request capture and per-point datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mode_r <= in_tuser[0];
          id_r   <= in_tdata[31:0];
          px_r   <= in_tdata[63:32];
          py_r   <= in_tdata[95:64];
          vx_r   <= in_tdata[127:96];
          vy_r   <= in_tdata[159:128];
          hd_r   <= in_tdata[178:160];
          lat_r  <= in_tdata[210:179];
          spd_r  <= '0;
          idx_r  <= '0;
          t_r    <= '0;
          trem_r <= '0;
        end
      end
      mps_pkg::ST_CNT: begin
        if (div_rsp.done) cnt_r <= cnt_nxt;
      end
      mps_pkg::ST_HDIV: begin
        if (div_rsp.done) begin
          hq_r <= div_rsp.quot[23:0];
          hr_r <= div_rsp.rem[CW-1:0];
        end
      end
      mps_pkg::ST_SQ: begin
        if (op_r == 3'd1) sq_r <= mul_p[63:0];
      end
      mps_pkg::ST_VEC: begin
        if (vec_rsp.done) begin
          hd_r  <= vec_rsp.heading;
          spd_r <= vec_rsp.speed;
        end
      end
      mps_pkg::ST_PT: begin
        case (op_r)
          3'd1: t2_r <= rnd16[32:0];
          3'd2: qx_r <= mps_pkg::sat32($signed({{16{px_r[31]}}, px_r}) +
                                       $signed(rnd16[47:0]));
          3'd3: qy_r <= mps_pkg::sat32($signed({{16{py_r[31]}}, py_r}) +
                                       $signed(rnd16[47:0]));
          3'd4: sa_r <= mps_pkg::satu31({17'b0, sig0_r} + rnd16[47:0]);
          3'd5: sc_r <= mps_pkg::sat32($signed({17'b0, sig0_r}) +
                                       $signed(rnd17[47:0]));
          3'd6: begin
            out_tuser_r <= mode_r;
            out_tlast_r <= last_pt;
            out_tdata_r <= {6'b0,
                            mode_r ? sc_r : $signed({1'b0, ss}),
                            mode_r ? {1'b0, sa_r} : {1'b0, ss},
                            spd_r, hd_r,
                            mode_r ? qy_r : py_r,
                            mode_r ? qx_r : px_r,
                            t_r, id_r};
          end
          default: t2_r <= t2_r;
        endcase
      end
      mps_pkg::ST_OUT: begin
        // advance time by horizon/count with a carried remainder
        if (out_tready && !last_pt) begin
          idx_r <= idx_r + CW'(1);
          if (rem_sum >= {1'b0, cnt_r}) begin
            trem_r <= CW'(rem_sum - {1'b0, cnt_r});
            t_r    <= t_r + hq_r + 24'd1;
          end else begin
            trem_r <= rem_sum[CW-1:0];
            t_r    <= t_r + hq_r;
          end
        end
      end
      default: t_r <= t_r;
    endcase
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_tlast = out_tlast_r;

`ifndef SYNTH
  // no request is taken while a point waits
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request accepted while a point is pending");

  // the final point returns the block to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not idle after final point");

  // a new request needs setup before any point appears
  a_no_early_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid && !in_tready)
    else $error("point presented right after a request");
`endif

endmodule

// ===== bench/motion_path_sampler_unit_test.sv =====
// self-checking testbench for the motion path sampler unit
module motion_path_sampler_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_INTERVALS = 63;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    bit          act;
    logic [215:0] data;
  } target_req_t;

  typedef struct {
    logic [31:0] id;
    logic        kind;
    logic [23:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [18:0] hd;
    logic [30:0] spd;
    logic [31:0] sa;
    logic [31:0] sc;
    logic        last;
  } path_point_t;

  // arctangent steps in Q.24
  localparam longint ATAN_STEP [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [239:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;

  // shadow copy of the configuration
  longint unsigned horizon_q = mps_pkg::HORIZON_RST;
  longint unsigned step_q = mps_pkg::STEP_RST;
  longint unsigned sigma0_q = mps_pkg::SIGMA0_RST;
  longint unsigned start_acc_q = mps_pkg::START_ACC_RST;
  longint unsigned speed_rate_q = mps_pkg::SPEED_RT_RST;

  target_req_t request_queue[$];
  path_point_t pending_points[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int long_hold_cnt = 0;
  int long_hold_req = 0;
  int long_hold_seen = 0;
  bit burst_send = 1'b0;
  bit burst_recv = 1'b0;

  motion_path_sampler_unit #(.MAX_INTERVALS(MAX_INTERVALS)) dut (.*);

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // vectoring rotation giving the velocity angle in Q3.16
  function automatic longint velocity_angle(input longint vx, input longint vy);
    longint x, y, z, xs, ys, r;
    x = vx <<< 29;
    y = vy <<< 29;
    z = 0;
    if (x < 0) begin
      z = (vy >= 0) ? 64'sd52707179 : -64'sd52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
      end
    end
    r = rnd_shift(z, 8);
    if (r > 205887) r = 205887;
    if (r < -205887) r = -205887;
    return r;
  endfunction

  // predicted path for one accepted target request
  function automatic void predict_path(input bit act, input logic [215:0] d);
    longint unsigned cnt, t, t2, g, s, a, spd, ax, ay;
    longint px, py, vx, vy, yaw, lat, hd, qx, qy, sc;
    path_point_t p;
    px = longint'($signed(d[63:32]));
    py = longint'($signed(d[95:64]));
    vx = longint'($signed(d[127:96]));
    vy = longint'($signed(d[159:128]));
    yaw = longint'($signed(d[178:160]));
    lat = longint'($signed(d[210:179]));
    if (step_q == 0) cnt = MAX_INTERVALS;
    else cnt = (horizon_q + step_q - 1) / step_q;
    if (cnt > MAX_INTERVALS) cnt = MAX_INTERVALS;
    if (cnt == 0) cnt = 1;
    if (!act || (vx == 0 && vy == 0)) begin
      hd = yaw;
      spd = 0;
    end else begin
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      spd = root_floor(ax * ax + ay * ay);
      if (spd > 64'h7FFFFFFF) spd = 64'h7FFFFFFF;
      hd = velocity_angle(vx, vy);
    end
    for (longint unsigned i = 0; i <= cnt; i++) begin
      t = (horizon_q * i) / cnt;
      t2 = (t * t + 32768) >> 16;
      p.id = d[31:0];
      p.kind = act;
      p.t = t[23:0];
      p.hd = hd[18:0];
      p.spd = spd[30:0];
      p.last = (i == cnt);
      if (!act) begin
        g = (start_acc_q * t2 + 65536) >> 17;
        s = sigma0_q + g;
        if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
        p.px = px[31:0];
        p.py = py[31:0];
        p.sa = s[31:0];
        p.sc = s[31:0];
      end else begin
        a = sigma0_q + ((speed_rate_q * t + 32768) >> 16);
        if (a > 64'h7FFFFFFF) a = 64'h7FFFFFFF;
        qx = sat_s32(px + rnd_shift(vx * longint'(t), 16));
        qy = sat_s32(py + rnd_shift(vy * longint'(t), 16));
        sc = sat_s32(longint'(sigma0_q) + rnd_shift(lat * longint'(t2), 17));
        p.px = qx[31:0];
        p.py = qy[31:0];
        p.sa = a[31:0];
        p.sc = sc[31:0];
      end
      pending_points.insert(pending_points.size(), p);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    target_req_t r;
    bit nv;
    nv = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_path(in_tuser[0], in_tdata);
      if (in_tvalid && !in_tready) begin
        nv = 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (request_queue.size() > 0) begin
        r = request_queue.pop_front();
        in_tdata <= r.data;
        in_tuser <= r.act;
        nv = 1'b1;
        if ($urandom_range(0, 15) == 0) burst_send <= ~burst_send;
        send_gap <= burst_send ? 0 : $urandom_range(0, 4);
      end
    end
    in_tvalid <= nv;
  end

  // point monitor and receiver stalls
  always @(posedge clk) begin
    path_point_t e;
    bit nr;
    nr = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected point, expected none got %0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          e = pending_points.pop_front();
          check_field("tgt_ident", e.id, out_tdata[31:0]);
          check_field("model_kind", e.kind, out_tuser[0]);
          check_field("sample_time", e.t, out_tdata[55:32]);
          check_field("pred_x", e.px, out_tdata[87:56]);
          check_field("pred_y", e.py, out_tdata[119:88]);
          check_field("heading", e.hd, out_tdata[138:120]);
          check_field("speed", e.spd, out_tdata[169:139]);
          check_field("sigma_along", e.sa, out_tdata[201:170]);
          check_field("sigma_cross", e.sc, out_tdata[233:202]);
          check_field("last", e.last, out_tlast);
        end
        if ($urandom_range(0, 31) == 0) burst_recv <= ~burst_recv;
        recv_stall <= burst_recv ? 0 : $urandom_range(0, 4);
      end else if (long_hold_req != long_hold_seen) begin
        long_hold_seen <= long_hold_req;
        long_hold_cnt <= LONG_HOLD;
      end else if (long_hold_cnt > 0) begin
        long_hold_cnt <= long_hold_cnt - 1;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
      end else begin
        nr = 1'b1;
      end
    end
    out_tready <= nr;
  end

  function automatic void add_target(input bit act, input logic [31:0] id,
                                     input logic [31:0] px, input logic [31:0] py,
                                     input logic [31:0] vx, input logic [31:0] vy,
                                     input logic [18:0] yaw, input logic [31:0] lat);
    target_req_t r;
    r.act = act;
    r.data = {5'd0, lat, yaw, vy, vx, py, px, id};
    request_queue.insert(request_queue.size(), r);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 20000) - 10000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic void add_random_target();
    logic [31:0] vx, vy;
    vx = pick_value();
    vy = pick_value();
    if ($urandom_range(0, 7) == 0) begin
      vx = '0;
      vy = '0;
    end
    add_target($urandom_range(0, 1), $urandom, pick_value(), pick_value(), vx, vy,
               19'($urandom), pick_value());
  endfunction

  // wait until the block has drained and settled back to idle
  task automatic wait_idle();
    while (request_queue.size() > 0 || in_tvalid || pending_points.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [30:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      mps_pkg::CFG_HORIZON:   horizon_q = v[23:0];
      mps_pkg::CFG_STEP:      step_q = v[23:0];
      mps_pkg::CFG_SIGMA0:    sigma0_q = v;
      mps_pkg::CFG_START_ACC: start_acc_q = v;
      mps_pkg::CFG_SPEED_RT:  speed_rate_q = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] h, input logic [23:0] s,
                            input logic [30:0] s0, input logic [30:0] acc,
                            input logic [30:0] rt);
    write_cfg(mps_pkg::CFG_HORIZON, h);
    write_cfg(mps_pkg::CFG_STEP, s);
    write_cfg(mps_pkg::CFG_SIGMA0, s0);
    write_cfg(mps_pkg::CFG_START_ACC, acc);
    write_cfg(mps_pkg::CFG_SPEED_RT, rt);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [30:0] pick_rate();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 200000);
      1: return 31'($urandom);
      default: return $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'd0;
    endcase
  endfunction

  // stimulus sequence
  initial begin
    logic [23:0] h;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed targets under reset configuration
    add_target(0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 19'h0, 32'h0);
    add_target(1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 19'sd205887, 32'h7FFFFFFF);
    add_target(1, 32'h1234, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, -19'sd205887, 32'h80000000);
    // zero velocity takes yaw, including yaw out of range
    add_target(1, 32'h5, 32'h10000, 32'h20000, 32'h0, 32'h0, 19'h3FFFF, 32'h10000);
    add_target(1, 32'h6, 32'h10000, 32'h20000, 32'h0, 32'h0, 19'h40000, 32'h10000);
    add_target(0, 32'h7, 32'h10000, 32'hFFFF0000, 32'h50000, 32'h0, 19'h40000, 32'h0);
    // negative x velocity with both y signs, and axis directions
    add_target(1, 32'h8, 32'h0, 32'h0, 32'hFFFF0000, 32'h00010000, 19'h0, 32'h0);
    add_target(1, 32'h9, 32'h0, 32'h0, 32'hFFFF0000, 32'hFFFF0000, 19'h0, 32'h0);
    add_target(1, 32'hA, 32'h0, 32'h0, 32'hFFFF0000, 32'h0, 19'h0, 32'h0);
    add_target(1, 32'hB, 32'h0, 32'h0, 32'h0, 32'h00010000, 19'h0, 32'h0);
    add_target(1, 32'hC, 32'h0, 32'h0, 32'h0, 32'hFFFF0000, 19'h0, 32'h0);
    // negative lateral acceleration drives cross sigma below zero
    add_target(1, 32'hD, 32'h0, 32'h0, 32'h00030000, 32'h00040000, 19'h0, 32'hFF000000);
    add_target(0, 32'hE, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 19'h7FFFF, 32'h1);
    wait_idle();

    // zero horizon gives two points at time zero
    set_config(24'd0, 24'd32768, 31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_target(0, 32'h20, 32'h0, 32'h0, 32'h10000, 32'h0, 19'h0, 32'h0);
    add_target(1, 32'h21, 32'h0, 32'h0, 32'h10000, 32'h0, 19'h0, 32'h80000000);
    wait_idle();

    // zero step and the largest horizon: longest paths, receiver held off
    set_config(24'hFFFFFF, 24'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    add_target(0, 32'h30, 32'h1, 32'h2, 32'h3, 32'h4, 19'h5, 32'h6);
    add_target(1, 32'h31, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 19'h0, 32'h7FFFFFFF);
    add_target(1, 32'h32, 32'h0, 32'h0, 32'h80000000, 32'h1, 19'h0, 32'h80000000);
    long_hold_req = long_hold_req + 1;
    wait_idle();

    // one interval per path, smallest nonzero horizon
    set_config(24'd1, 24'hFFFFFF, 31'd0, 31'd0, 31'd0);
    add_target(1, 32'h40, 32'h0, 32'h0, 32'h100, 32'h200, 19'h0, 32'h0);
    add_target(0, 32'h41, 32'h0, 32'h0, 32'h100, 32'h200, 19'h0, 32'h0);
    wait_idle();

    // random phases with random configuration
    for (int ph = 0; ph < 9; ph++) begin
      h = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 1000000));
      set_config(h, $urandom_range(0, 9) == 0 ? 24'($urandom) :
                 24'(h / $urandom_range(1, 12) + 1), pick_rate(), pick_rate(), pick_rate());
      for (int k = 0; k < 16; k++) add_random_target();
      if (ph == 4) long_hold_req = long_hold_req + 1;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
